### rtl/slpc_pkg.sv
// shared types and constants for the shape list pixel coverage block
`default_nettype none
package slpc_pkg;

  localparam int unsigned MaxShapesDefault = 128;

  localparam int unsigned KindW   = 2;
  localparam int unsigned TypeW   = 2;
  localparam int unsigned CoordW  = 13;
  localparam int unsigned SizeW   = 12;
  localparam int unsigned PixW    = 12;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ColorW-1:0] FillReset = 8'd255;

  localparam logic [TypeW-1:0] SHAPE_SQUARE = 2'd1;
  localparam logic [TypeW-1:0] SHAPE_CIRCLE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FILL_RED   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FILL_GREEN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FILL_BLUE  = 2'd2;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [TypeW-1:0]         shape_type;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [SizeW-1:0]         half_width;
    logic [SizeW-1:0]         half_height;
  } shape_t;

  typedef struct packed {
    logic append;
    logic clear;
    logic start;
    logic rd_en;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/slpc_ctrl.sv
// controller state machine: beat dispatch, list scan and result hand-off
`default_nettype none
module slpc_ctrl import slpc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [KindW-1:0] kind_i,
  output logic                  in_stall_o,
  input  wire status_t          status_i,
  output cmd_t                  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (kind_i)
            KIND_APPEND: cmd_o.append = 1'b1;
            KIND_CLEAR:  cmd_o.clear  = 1'b1;
            KIND_QUERY: begin
              cmd_o.start = 1'b1;
              state_d     = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/slpc_datapath.sv
// datapath: shape memory, list count, hit test pipeline, fill registers, output register
`default_nettype none
module slpc_datapath import slpc_pkg::*; #(
  parameter int unsigned MAX_SHAPES = MaxShapesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output status_t                       status_o,
  input  wire logic [TypeW-1:0]         shape_type_i,
  input  wire logic signed [CoordW-1:0] center_x_i,
  input  wire logic signed [CoordW-1:0] center_y_i,
  input  wire logic [SizeW-1:0]         half_width_i,
  input  wire logic [SizeW-1:0]         half_height_i,
  input  wire logic [PixW-1:0]          pixel_x_i,
  input  wire logic [PixW-1:0]          pixel_y_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ColorW-1:0]        cfg_data_i,
  input  wire logic                     out_stall_i,
  output logic                          out_valid_o,
  output logic                          covered_o,
  output logic [ColorW-1:0]             out_red_o,
  output logic [ColorW-1:0]             out_green_o,
  output logic [ColorW-1:0]             out_blue_o
);

  localparam int unsigned CntW  = $clog2(MAX_SHAPES + 1);
  localparam int unsigned AddrW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int unsigned DW    = CoordW + 1;
  localparam int unsigned SqW   = 2 * DW - 1;
  localparam int unsigned RSqW  = 2 * SizeW;

  shape_t mem [MAX_SHAPES];

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              full;
  logic [PixW-1:0]   px_q, py_q;
  logic [ColorW-1:0] fill_red_q, fill_green_q, fill_blue_q;

  // stage 1: registered memory read
  shape_t rd_q;
  logic   v1_q;

  // stage 2: differences, squares and box test
  logic signed [DW-1:0]   cx_s, cy_s, hw_s, hh_s, px_s, py_s, dx, dy;
  logic signed [2*DW-1:0] dx_sq, dy_sq;
  logic [RSqW-1:0]        r_sq;
  logic                   box_hit;
  logic [SqW-1:0]         dx2_q, dy2_q;
  logic [RSqW-1:0]        r2_q;
  logic                   circ_q, box_q, v2_q;

  // stage 3: circle compare and coverage accumulate
  logic [SqW:0] d2;
  logic         hit;
  logic         cov_q;

  logic              out_valid_q, covered_q;
  logic [ColorW-1:0] red_q, green_q, blue_q;

  assign full = (count_q == CntW'(MAX_SHAPES));

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append && !full) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.start) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_en) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[count_q[AddrW-1:0]] <= '{shape_type:  shape_type_i,
                                   center_x:    center_x_i,
                                   center_y:    center_y_i,
                                   half_width:  half_width_i,
                                   half_height: half_height_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_red_q   <= FillReset;
      fill_green_q <= FillReset;
      fill_blue_q  <= FillReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FILL_RED:   fill_red_q   <= cfg_data_i;
        REG_FILL_GREEN: fill_green_q <= cfg_data_i;
        REG_FILL_BLUE:  fill_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cx_s    = DW'(rd_q.center_x);
    cy_s    = DW'(rd_q.center_y);
    hw_s    = $signed({{(DW-SizeW){1'b0}}, rd_q.half_width});
    hh_s    = $signed({{(DW-SizeW){1'b0}}, rd_q.half_height});
    px_s    = $signed({{(DW-PixW){1'b0}}, px_q});
    py_s    = $signed({{(DW-PixW){1'b0}}, py_q});
    dx      = cx_s - px_s;
    dy      = cy_s - py_s;
    dx_sq   = (2*DW)'(dx) * (2*DW)'(dx);
    dy_sq   = (2*DW)'(dy) * (2*DW)'(dy);
    r_sq    = RSqW'(rd_q.half_width) * RSqW'(rd_q.half_width);
    box_hit = (px_s > cx_s - hw_s) && (px_s < cx_s + hw_s) &&
              (py_s > cy_s - hh_s) && (py_s < cy_s + hh_s);
  end

  always_ff @(posedge clk_i) begin
    dx2_q  <= dx_sq[SqW-1:0];
    dy2_q  <= dy_sq[SqW-1:0];
    r2_q   <= r_sq;
    circ_q <= (rd_q.shape_type == SHAPE_CIRCLE);
    box_q  <= (rd_q.shape_type == SHAPE_SQUARE) && box_hit;
  end

  assign d2  = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign hit = box_q || (circ_q && (d2 <= (SqW+1)'(r2_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      cov_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        cov_q <= 1'b0;
      end else if (v2_q && hit) begin
        cov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      covered_q <= cov_q;
      red_q     <= cov_q ? fill_red_q   : '0;
      green_q   <= cov_q ? fill_green_q : '0;
      blue_q    <= cov_q ? fill_blue_q  : '0;
    end
  end

  assign status_o.scan_done = (rd_idx_q == count_q);
  assign status_o.pipe_busy = v1_q | v2_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign covered_o   = covered_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SHAPES))
    else $error("shape count beyond list depth");

  a_read_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (rd_idx_q < count_q))
    else $error("read past end of shape list");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_q == '0))
    else $error("clear did not empty the list");

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!v1_q && !v2_q))
    else $error("result loaded with hit test still in flight");

  a_black_uncovered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !covered_q) |-> (red_q == '0 && green_q == '0 && blue_q == '0))
    else $error("uncovered pixel not black");

endmodule
`default_nettype wire

### rtl/shape_list_pixel_coverage.sv
// top level of the shape list pixel coverage block
// append and clear beats are taken without a stall; kind 3 beats are taken and dropped
// a query result is registered after the scan of the N listed shapes and the hit test drain
// input stalls from query accept until the result is loaded, longer while a result waits
// the scan reads one shape per cycle from the shape memory
// reset empties the list and sets all fill colors to 255; memory contents stay undefined
`default_nettype none
module shape_list_pixel_coverage import slpc_pkg::*; #(
  parameter int unsigned MAX_SHAPES = MaxShapesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [KindW-1:0]         kind_i,
  input  wire logic [TypeW-1:0]         shape_type_i,
  input  wire logic signed [CoordW-1:0] center_x_i,
  input  wire logic signed [CoordW-1:0] center_y_i,
  input  wire logic [SizeW-1:0]         half_width_i,
  input  wire logic [SizeW-1:0]         half_height_i,
  input  wire logic [PixW-1:0]          pixel_x_i,
  input  wire logic [PixW-1:0]          pixel_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          covered_o,
  output logic [ColorW-1:0]             out_red_o,
  output logic [ColorW-1:0]             out_green_o,
  output logic [ColorW-1:0]             out_blue_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ColorW-1:0]        cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  slpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slpc_datapath #(
    .MAX_SHAPES (MAX_SHAPES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .shape_type_i  (shape_type_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .half_width_i  (half_width_i),
    .half_height_i (half_height_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .covered_o     (covered_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o)
  );

endmodule
`default_nettype wire
